// ===== rtl/sha1_pkg.sv =====
// SHA-1 digest unit: shared types, constants and helper functions.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps
package sha1_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenPos     = 56;
   localparam int unsigned Rounds     = 80;
   localparam int unsigned DigestBytes = 20;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;
   localparam logic [7:0]  PadByte = 8'h80;
   localparam logic        HexOutputReset = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_PAD_FILL,
      ST_EMIT
   } state_type;

   // Buffer write source: message bytes, or pad, zero and length bytes for the pad sweep
   typedef enum logic [1:0] {
      WR_DATA,
      WR_PAD,
      WR_ZERO,
      WR_LEN
   } wr_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic       buf_we;
      wr_sel_type wr_sel;
      logic [5:0] wr_addr;
      logic       cnt_add;
      logic       load_work;
      logic       round_en;
      logic [6:0] round;
      logic       fold;
      logic       clear;
      logic [5:0] rd_addr;
   } cmd_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) hex_char = 8'h30 + {4'h0, nib};
      else             hex_char = 8'h57 + {4'h0, nib};
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] r);
      if (r < 7'd20)      round_k = K0;
      else if (r < 7'd40) round_k = K1;
      else if (r < 7'd60) round_k = K2;
      else                round_k = K3;
   endfunction

endpackage

// ===== rtl/sha1_datapath.sv =====
// SHA-1 datapath: block buffer memory, bit counter, message schedule,
// round unit and chaining words. Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_datapath
   import sha1_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [7:0]    data_byte,
   input  logic [4:0]    digest_sel,
   output logic [7:0]    digest_byte
);

   logic [7:0]   mem [BlockBytes];
   logic [7:0]   rd_data_ff;
   logic [63:0]  bit_count_ff, bit_count_in;
   logic [31:0]  h_ff [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  w_ff [16];
   logic [7:0]   wr_data;
   logic [31:0]  w_new, f_val, t_val, w_cur;
   logic [159:0] h_flat;

   // Buffer write data mux; length bytes big-endian at 56..63
   always_comb begin
      case (cmd.wr_sel)
         WR_DATA: wr_data = data_byte;
         WR_PAD:  wr_data = PadByte;
         WR_ZERO: wr_data = 8'h00;
         default: wr_data = bit_count_ff[8 * (7 - cmd.wr_addr[2:0]) +: 8];
      endcase
   end

   // Block buffer memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.buf_we) mem[cmd.wr_addr] <= wr_data;
      rd_data_ff <= mem[cmd.rd_addr];
   end

   // Message bit counter, wraps at 2^64
   always_comb begin
      bit_count_in = bit_count_ff;
      if (cmd.clear)        bit_count_in = '0;
      else if (cmd.cnt_add) bit_count_in = bit_count_ff + 64'd8;
   end

   always_ff @(posedge clock) begin
      if (reset) bit_count_ff <= '0;
      else       bit_count_ff <= bit_count_in;
   end

   // Schedule: 16-word window; bytes shift in during load, expand during rounds
   assign w_new = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1
                | {31'h0, w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};
   assign w_cur = (cmd.round < 7'd16) ? w_ff[0] : w_new;

   always_comb begin
      if (cmd.round < 7'd20)      f_val = (b_ff & c_ff) | (~b_ff & d_ff);
      else if (cmd.round < 7'd40) f_val = b_ff ^ c_ff ^ d_ff;
      else if (cmd.round < 7'd60) f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
      else                        f_val = b_ff ^ c_ff ^ d_ff;
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + w_cur + round_k(cmd.round);

   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         // byte shifts into low end of last word
         for (int i = 0; i < 15; i++) w_ff[i] <= {w_ff[i][23:0], w_ff[i + 1][31:24]};
         w_ff[15] <= {w_ff[15][23:0], rd_data_ff};
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
         d_ff <= h_ff[3]; e_ff <= h_ff[4];
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_cur;
         a_ff <= t_val;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   // Chaining words
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         h_ff[0] <= H0; h_ff[1] <= H1; h_ff[2] <= H2; h_ff[3] <= H3; h_ff[4] <= H4;
      end else if (cmd.fold) begin
         h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
         h_ff[4] <= h_ff[4] + e_ff;
      end
   end

   assign h_flat = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
   assign digest_byte = h_flat[8 * (DigestBytes - 1 - 32'(digest_sel)) +: 8];

endmodule

// ===== rtl/sha1_ctrl.sv =====
// SHA-1 controller: sequences byte intake, block load, rounds, padding
// and digest output. Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_ctrl
   import sha1_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_last,
   output logic       rsp_hi_nib,
   input  logic       hex_output,
   output logic [4:0] digest_sel,
   output cmd_type    cmd
);

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        final_ff, final_in;     // pad byte still to be written
   logic        lenblk_ff, lenblk_in;   // next compression carries length
   logic        lenpend_ff, lenpend_in; // length needs a block of its own
   logic [5:0]  out_ff, out_in;
   logic        accept;
   logic        rsp_done;

   assign accept = req_valid && req_ready;
   assign rsp_done = rsp_valid && rsp_ready;

   // Next state
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      cnt_in     = cnt_ff;
      final_in   = final_ff;
      lenblk_in  = lenblk_ff;
      lenpend_in = lenpend_ff;
      out_in     = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.byte_present) fill_in = fill_ff + 6'd1;
               cnt_in = '0;
               if (req_data.byte_present && fill_ff == 6'd63) begin
                  final_in = req_data.last;
                  state_in = ST_LOAD;
               end else if (req_data.last) begin
                  final_in = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_LOAD: begin
            // registered buffer read first, then 64 bytes shift in
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) begin
               cnt_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(Rounds - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cnt_in = '0;
            if (lenblk_ff) begin
               lenblk_in = 1'b0;
               final_in  = 1'b0;
               out_in    = '0;
               state_in  = ST_EMIT;
            end else if (lenpend_ff) begin
               // zeros and length sweep from address 0
               lenpend_in = 1'b0;
               lenblk_in  = 1'b1;
               state_in   = ST_PAD_FILL;
            end else if (final_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // pad byte at fill; length fits only if fill < 56
            fill_in    = fill_ff + 6'd1;
            final_in   = 1'b0;
            lenblk_in  = fill_ff < 6'(LenPos);
            lenpend_in = fill_ff >= 6'(LenPos);
            state_in = (fill_ff == 6'd63) ? ST_LOAD : ST_PAD_FILL;
            if (fill_ff == 6'd63) fill_in = '0;
         end
         ST_PAD_FILL: begin
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               fill_in  = '0;
               cnt_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (rsp_done) begin
               out_in = out_ff + 6'd1;
               if (rsp_last) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      cmd.wr_sel  = WR_DATA;
      cmd.wr_addr = fill_ff;
      cmd.rd_addr = cnt_ff[5:0];
      cmd.round   = cnt_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.buf_we  = accept && req_data.byte_present;
            cmd.cnt_add = accept && req_data.byte_present;
         end
         ST_LOAD: cmd.load_work = cnt_ff != 7'd0;
         ST_ROUND: cmd.round_en = 1'b1;
         ST_FOLD: cmd.fold = 1'b1;
         ST_PAD: begin
            cmd.buf_we = 1'b1;
            cmd.wr_sel = WR_PAD;
         end
         ST_PAD_FILL: begin
            cmd.buf_we = 1'b1;
            cmd.wr_sel = (lenblk_ff && fill_ff >= 6'(LenPos)) ? WR_LEN : WR_ZERO;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.clear = rsp_done && rsp_last;
         end
         default: ;
      endcase
   end

   assign digest_sel = hex_output ? out_ff[5:1] : out_ff[4:0];
   assign rsp_hi_nib = hex_output && !out_ff[0];
   assign rsp_last   = hex_output ? (out_ff == 6'd39) : (out_ff == 6'd19);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         cnt_ff     <= '0;
         final_ff   <= 1'b0;
         lenblk_ff  <= 1'b0;
         lenpend_ff <= 1'b0;
         out_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cnt_ff     <= cnt_in;
         final_ff   <= final_in;
         lenblk_ff  <= lenblk_in;
         lenpend_ff <= lenpend_in;
         out_ff     <= out_in;
      end
   end

endmodule

// ===== rtl/sha1_message_digest_unit.sv =====
// SHA-1 digest unit top level: controller, datapath and the format register.
// Depends on sha1_pkg, sha1_ctrl and sha1_datapath.
`timescale 1ns / 1ps
// Byte-in SHA-1 engine. A beat that carries a byte is accepted whenever the engine
// is idle; the 64th byte of a block then holds off the input while the schedule
// loads from the block buffer one byte a cycle, the 80 rounds run on one shared
// round unit and the fold is done. A last beat adds a padding sweep from the fill
// position to the end of the block and a compression; when more than 55 bytes
// are pending, a second sweep and compression follow. Then come 20 raw or 40 hex
// digest beats, one per cycle when the consumer is ready. Message state returns
// to reset after the final digest beat; the hex_output format bit is kept.
module sha1_message_digest_unit
   import sha1_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   logic       hex_ff;
   cmd_type    cmd;
   logic [4:0] digest_sel;
   logic [7:0] digest_byte;
   logic       hi_nib;
   logic       last_beat;

   // Format register
   always_ff @(posedge clock) begin
      if (reset)       hex_ff <= HexOutputReset;
      else if (csr_we) hex_ff <= csr_wdata;
   end

   sha1_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_last(last_beat), .rsp_hi_nib(hi_nib),
      .hex_output(hex_ff), .digest_sel, .cmd
   );

   sha1_datapath u_dp (
      .clock, .reset, .cmd, .data_byte(req_data.data_byte),
      .digest_sel, .digest_byte
   );

   // Output beat formatting
   always_comb begin
      rsp_data.out_last = last_beat;
      if (!hex_ff)     rsp_data.out_byte = digest_byte;
      else if (hi_nib) rsp_data.out_byte = hex_char(digest_byte[7:4]);
      else             rsp_data.out_byte = hex_char(digest_byte[3:0]);
   end

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken during digest output");

   a_last_ends_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.out_last |=> !rsp_valid)
      else $error("output continued after final beat");

endmodule

// ===== test/sha1_message_digest_unit_tb.sv =====
// Testbench for the SHA-1 digest unit: streams messages byte by byte and checks
// each digest beat against a built-in SHA-1 predictor. Depends on sha1_pkg and the RTL.
`timescale 1ns / 1ps
module sha1_message_digest_unit_tb;
   import sha1_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_wdata;

   sha1_message_digest_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [7:0]  msg_block [64];
   int unsigned msg_fill;
   logic [31:0] chain [5];
   logic [63:0] msg_bits;
   logic        hex_mode;

   rsp_type digest_q [$];
   int unsigned mismatches;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [7:0] to_hex(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + nib : 8'h61 + (nib - 4'd10);
   endfunction

   task automatic compress_msg_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, t, k;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = K0;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K2;
         end else begin
            f = b ^ c ^ d; k = K3;
         end
         t = rotl(a, 5) + f + e + w[i] + k;
         e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
   endtask

   task automatic clear_msg();
      foreach (msg_block[i]) msg_block[i] = 8'h00;
      msg_fill = 0;
      chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
      msg_bits = '0;
   endtask

   // Advance the predictor by one accepted beat; queue digest beats on last
   task automatic predict_digest(input req_type beat);
      logic [7:0] dbyte;
      rsp_type r;
      if (beat.byte_present) begin
         msg_block[msg_fill] = beat.data_byte;
         msg_fill = (msg_fill + 1) % 64;
         msg_bits += 64'd8;
         if (msg_fill == 0) compress_msg_block();
      end
      if (!beat.last) return;
      msg_block[msg_fill] = PadByte;
      for (int i = msg_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (msg_fill >= LenPos) begin
         compress_msg_block();
         for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[LenPos + i] = msg_bits[63 - 8*i -: 8];
      compress_msg_block();
      for (int i = 0; i < 20; i++) begin
         dbyte = chain[i/4][31 - 8*(i%4) -: 8];
         if (hex_mode) begin
            r.out_byte = to_hex(dbyte[7:4]); r.out_last = 1'b0;
            digest_q.push_back(r);
            r.out_byte = to_hex(dbyte[3:0]); r.out_last = (i == 19);
            digest_q.push_back(r);
         end else begin
            r.out_byte = dbyte; r.out_last = (i == 19);
            digest_q.push_back(r);
         end
      end
      clear_msg();
   endtask

   // Offer one beat, hold until accepted, then idle at random
   task automatic send_beat(input logic [7:0] b, input logic present, input logic fin);
      req_type beat;
      beat.data_byte = b; beat.byte_present = present; beat.last = fin;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock iff req_ready);
      predict_digest(beat);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic release_bus();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      // block may still be clearing after the last digest beat
      repeat (20) @(posedge clock);
   endtask

   task automatic write_format(input logic hex);
      csr_we    <= 1'b1;
      csr_wdata <= hex;
      @(posedge clock);
      csr_we    <= 1'b0;
      hex_mode   = hex;
   endtask

   task automatic send_message(input int len, input logic empty_tail);
      for (int i = 0; i < len; i++)
         send_beat(8'($urandom_range(255)), 1'b1, !empty_tail && i == len - 1);
      if (empty_tail || len == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // Result checker: compares every accepted beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h/%b", rsp_data.out_byte,
                                           rsp_data.out_last);
         end else begin
            if (rsp_data !== digest_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("digest beat mismatch: expected %h/%b got %h/%b",
                           digest_q[0].out_byte, digest_q[0].out_last,
                           rsp_data.out_byte, rsp_data.out_last);
            end
            void'(digest_q.pop_front());
         end
      end
   end

   // Receiver stall; a long hold-off overrides the random idling
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Empty message, extremes of data, padding boundaries, empty final beat
   task automatic test_directed();
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hA5, 1'b1, 1'b1);
      send_beat(8'h5A, 1'b0, 1'b1);
      wait_drained();
      write_format(1'b0);
      send_message(55, 1'b0);
      send_message(56, 1'b0);
   endtask

   // Block boundaries in raw mode, then back to hex
   task automatic test_block_edges();
      send_message(63, 1'b0);
      wait_drained();
      write_format(1'b1);
      send_message(64, 1'b0);
   endtask

   // Long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      hold_cycles = 400;
      for (int m = 0; m < 4; m++) send_message($urandom_range(6), 1'b0);
      wait_drained();
   endtask

   task automatic test_random_messages(input int beats);
      int sent;
      int len;
      sent = 0;
      while (sent < beats) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(72, 56) : $urandom_range(12);
         send_message(len, $urandom_range(3) == 0);
         sent += len + 1;
         if ($urandom_range(5) == 0) begin
            wait_drained();
            write_format(1'($urandom_range(1)));
         end
      end
      wait_drained();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = 1'b0;
      mismatches    = 0;
      hold_cycles   = 0;
      hex_mode      = HexOutputReset;
      send_idle_pct = 28;
      recv_idle_pct = 51;
      clear_msg();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_block_edges();
      wait_drained();
      write_format(1'b0);
      test_backpressure();
      write_format(1'b1);
      test_random_messages(15);
      send_idle_pct = 51;
      recv_idle_pct = 28;
      test_random_messages(15);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_messages(15);
      release_bus();

      if (mismatches == 0 && digest_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
